@@ rtl/core/hsv2rgb_pkg.sv @@
// shared types and fixed constants of the hsv to rgb converter
`default_nettype none

package hsv2rgb_pkg;

    localparam int HUE_W = 17;
    localparam int SAT_W = 9;
    localparam int VAL_W = 10;
    localparam int CH_W  = 8;
    localparam int LVL_W = 10;

    localparam logic [SAT_W-1:0] SAT_ONE = 9'd256;
    localparam logic [LVL_W-1:0] CH_MAX  = 10'd255;

    // floor(y / 60) = (y * DIV60_MUL) >> DIV60_SHIFT, exact for y < 2**Y_W
    localparam int          Y_W         = 16;
    localparam int          DIV60_SHIFT = 22;
    localparam logic [16:0] DIV60_MUL   = 17'd69906;
    localparam int          QP_W        = Y_W + 17;

    // hue sectors, each 60 degrees wide
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } t_sector;

    typedef struct packed {
        logic [SAT_W-1:0] sat;
        logic [VAL_W-1:0] val;
    } t_side;

    typedef struct packed {
        logic             grey;
        t_sector          sector;
        logic [VAL_W-1:0] val;
        logic [LVL_W-1:0] p;
        logic [QP_W-1:0]  q_prod;
        logic [QP_W-1:0]  t_prod;
    } t_lvl;

endpackage

`default_nettype wire

@@ rtl/core/hsv2rgb_hue.sv @@
// hue wrap modulo 360 degrees and split into sector and remainder, four stages
`default_nettype none

module hsv2rgb_hue #(
    parameter int  HUE_FRAC_BITS = 6,
    localparam int SPAN  = 60 << HUE_FRAC_BITS,
    localparam int REM_W = $clog2(SPAN + 1)
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_vld,
    output logic                                   o_rdy,
    input  wire signed [hsv2rgb_pkg::HUE_W-1:0]    i_hue,
    input  hsv2rgb_pkg::t_side                     i_side,
    output logic                                   o_vld,
    input  wire                                    i_rdy,
    output hsv2rgb_pkg::t_sector                   o_sector,
    output logic [REM_W-1:0]                       o_rem,
    output hsv2rgb_pkg::t_side                     o_side
);

    localparam int XW   = hsv2rgb_pkg::HUE_W;
    localparam int FULL = 360 << HUE_FRAC_BITS;
    localparam int HW   = $clog2(FULL);
    localparam int SH   = XW + HW;
    localparam int MW   = 19;
    localparam int PW   = XW + MW;
    localparam int QW   = (HW >= 18) ? 1 : 18 - HW;
    localparam int WW   = ((HW > XW) ? HW : XW) + 1;
    localparam int OFS  = 65536 % FULL;

    // reciprocal of the full circle, exact for every 17 bit operand
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << SH) + 64'(FULL) - 64'd1) / 64'(FULL));
    localparam logic [WW-1:0] OFS_W  = WW'(OFS);
    localparam logic [WW-1:0] FULL_W = WW'(FULL);
    localparam logic [HW-1:0] SEC_B1 = HW'(SPAN);
    localparam logic [HW-1:0] SEC_B2 = HW'(2 * SPAN);
    localparam logic [HW-1:0] SEC_B3 = HW'(3 * SPAN);
    localparam logic [HW-1:0] SEC_B4 = HW'(4 * SPAN);
    localparam logic [HW-1:0] SEC_B5 = HW'(5 * SPAN);

    logic [3:0] r_vld;
    logic [3:0] adv;

    logic [XW-1:0]      r_a_x;
    logic [PW-1:0]      r_a_prod;
    hsv2rgb_pkg::t_side r_a_side;

    logic [XW-1:0]      r_b_x;
    logic [XW-1:0]      r_b_qf;
    hsv2rgb_pkg::t_side r_b_side;

    logic [HW-1:0]      r_c_hue;
    hsv2rgb_pkg::t_side r_c_side;

    hsv2rgb_pkg::t_sector r_d_sector;
    logic [REM_W-1:0]     r_d_rem;
    hsv2rgb_pkg::t_side   r_d_side;

    logic [XW-1:0]      a_x;
    logic [QW-1:0]      b_q;
    logic [QW+HW-1:0]   b_qf_full;
    logic [WW-1:0]      c_rem;
    logic [WW-1:0]      c_wrap;
    hsv2rgb_pkg::t_sector d_sector;
    logic [HW-1:0]      d_base;

    // a stage moves when it is empty or the one after it moves
    assign adv[3] = !r_vld[3] || i_rdy;
    assign adv[2] = !r_vld[2] || adv[3];
    assign adv[1] = !r_vld[1] || adv[2];
    assign adv[0] = !r_vld[0] || adv[1];
    assign o_rdy  = adv[0];

    // offset by 65536 so the hue is non-negative
    assign a_x = {~i_hue[XW-1], i_hue[XW-2:0]};

    assign b_q       = QW'(r_a_prod >> SH);
    assign b_qf_full = (QW + HW)'(b_q) * (QW + HW)'(FULL);

    assign c_rem  = WW'(r_b_x) - WW'(r_b_qf);
    assign c_wrap = (c_rem >= OFS_W) ? c_rem - OFS_W : c_rem + FULL_W - OFS_W;

    always_comb begin
        priority if (r_c_hue >= SEC_B5) begin
            d_sector = hsv2rgb_pkg::SEC_MR;
            d_base   = SEC_B5;
        end else if (r_c_hue >= SEC_B4) begin
            d_sector = hsv2rgb_pkg::SEC_BM;
            d_base   = SEC_B4;
        end else if (r_c_hue >= SEC_B3) begin
            d_sector = hsv2rgb_pkg::SEC_CB;
            d_base   = SEC_B3;
        end else if (r_c_hue >= SEC_B2) begin
            d_sector = hsv2rgb_pkg::SEC_GC;
            d_base   = SEC_B2;
        end else if (r_c_hue >= SEC_B1) begin
            d_sector = hsv2rgb_pkg::SEC_YG;
            d_base   = SEC_B1;
        end else begin
            d_sector = hsv2rgb_pkg::SEC_RY;
            d_base   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_vld;
            if (adv[1]) r_vld[1] <= r_vld[0];
            if (adv[2]) r_vld[2] <= r_vld[1];
            if (adv[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_a_x    <= a_x;
            r_a_prod <= PW'(a_x) * PW'(RECIP);
            r_a_side <= i_side;
        end
        if (adv[1]) begin
            r_b_x    <= r_a_x;
            r_b_qf   <= b_qf_full[XW-1:0];
            r_b_side <= r_a_side;
        end
        if (adv[2]) begin
            r_c_hue  <= c_wrap[HW-1:0];
            r_c_side <= r_b_side;
        end
        if (adv[3]) begin
            r_d_sector <= d_sector;
            r_d_rem    <= REM_W'(r_c_hue - d_base);
            r_d_side   <= r_c_side;
        end
    end

    assign o_vld    = r_vld[3];
    assign o_sector = r_d_sector;
    assign o_rem    = r_d_rem;
    assign o_side   = r_d_side;

endmodule

`default_nettype wire

@@ rtl/core/hsv2rgb_level.sv @@
// p, q and t level products, three stages
`default_nettype none

module hsv2rgb_level #(
    parameter int  HUE_FRAC_BITS = 6,
    localparam int SPAN  = 60 << HUE_FRAC_BITS,
    localparam int REM_W = $clog2(SPAN + 1)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_vld,
    output logic                  o_rdy,
    input  hsv2rgb_pkg::t_sector  i_sector,
    input  wire [REM_W-1:0]       i_rem,
    input  hsv2rgb_pkg::t_side    i_side,
    output logic                  o_vld,
    input  wire                   i_rdy,
    output hsv2rgb_pkg::t_lvl     o_lvl
);

    localparam int VAL_W = hsv2rgb_pkg::VAL_W;
    localparam int SAT_W = hsv2rgb_pkg::SAT_W;
    localparam int LVL_W = hsv2rgb_pkg::LVL_W;
    localparam int QP_W  = hsv2rgb_pkg::QP_W;
    localparam int Y_W   = hsv2rgb_pkg::Y_W;
    localparam int DEN   = SPAN << 8;
    localparam int DW    = $clog2(DEN + 1);
    localparam int SRW   = SAT_W + REM_W;
    localparam int PVW   = VAL_W + SAT_W;
    localparam int VW    = VAL_W + DW;
    localparam int DSH   = 8 + HUE_FRAC_BITS;

    localparam logic [REM_W-1:0] SPAN_R = REM_W'(SPAN);
    localparam logic [DW-1:0]    DEN_D  = DW'(DEN);

    logic [2:0] r_vld;
    logic [2:0] adv;

    logic [SRW-1:0]       r_e_sr;
    logic [SRW-1:0]       r_e_srt;
    logic [PVW-1:0]       r_e_pv;
    logic                 r_e_grey;
    hsv2rgb_pkg::t_sector r_e_sector;
    logic [VAL_W-1:0]     r_e_val;

    logic [VW-1:0]        r_f_vq;
    logic [VW-1:0]        r_f_vt;
    logic [LVL_W-1:0]     r_f_p;
    logic                 r_f_grey;
    hsv2rgb_pkg::t_sector r_f_sector;
    logic [VAL_W-1:0]     r_f_val;

    hsv2rgb_pkg::t_lvl    r_g_lvl;

    logic [SAT_W-1:0] e_sat;
    logic [DW-1:0]    f_aq;
    logic [DW-1:0]    f_at;
    logic [Y_W-1:0]   g_yq;
    logic [Y_W-1:0]   g_yt;

    assign adv[2] = !r_vld[2] || i_rdy;
    assign adv[1] = !r_vld[1] || adv[2];
    assign adv[0] = !r_vld[0] || adv[1];
    assign o_rdy  = adv[0];

    // saturation above one counts as one
    assign e_sat = (i_side.sat > hsv2rgb_pkg::SAT_ONE) ? hsv2rgb_pkg::SAT_ONE : i_side.sat;

    assign f_aq = DEN_D - DW'(r_e_sr);
    assign f_at = DEN_D - DW'(r_e_srt);

    // divide by 256 * 2**frac first, the divide by 60 follows
    assign g_yq = Y_W'(r_f_vq >> DSH);
    assign g_yt = Y_W'(r_f_vt >> DSH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_vld;
            if (adv[1]) r_vld[1] <= r_vld[0];
            if (adv[2]) r_vld[2] <= r_vld[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_e_sr     <= SRW'(e_sat) * SRW'(i_rem);
            r_e_srt    <= SRW'(e_sat) * SRW'(SPAN_R - i_rem);
            r_e_pv     <= PVW'(i_side.val) * PVW'(hsv2rgb_pkg::SAT_ONE - e_sat);
            r_e_grey   <= (e_sat == '0);
            r_e_sector <= i_sector;
            r_e_val    <= i_side.val;
        end
        if (adv[1]) begin
            r_f_vq     <= VW'(r_e_val) * VW'(f_aq);
            r_f_vt     <= VW'(r_e_val) * VW'(f_at);
            r_f_p      <= LVL_W'(r_e_pv >> 8);
            r_f_grey   <= r_e_grey;
            r_f_sector <= r_e_sector;
            r_f_val    <= r_e_val;
        end
        if (adv[2]) begin
            r_g_lvl.q_prod <= QP_W'(g_yq) * QP_W'(hsv2rgb_pkg::DIV60_MUL);
            r_g_lvl.t_prod <= QP_W'(g_yt) * QP_W'(hsv2rgb_pkg::DIV60_MUL);
            r_g_lvl.p      <= r_f_p;
            r_g_lvl.grey   <= r_f_grey;
            r_g_lvl.sector <= r_f_sector;
            r_g_lvl.val    <= r_f_val;
        end
    end

    assign o_vld = r_vld[2];
    assign o_lvl = r_g_lvl;

endmodule

`default_nettype wire

@@ rtl/core/hsv_to_rgb_core.sv @@
// top level of the hsv to rgb pixel converter
`default_nettype none

// Converts one hue / saturation / value pixel per clock into 8-bit red, green
// and blue while the output is not stalled. The datapath is an 8-stage
// pipeline, which can take a new pixel every cycle under that condition.
// Parallel multipliers share a stage, no stage chains two of them, which sets
// the depth: four stages wrap the hue modulo 360 degrees with a reciprocal
// multiply and split it into sector and remainder, three form the p, q and t
// levels, and the last one picks the channels by sector and saturates them.
// Every stage carries a valid bit; a stage moves when it is empty or the stage
// after it moves, so bubbles close up and a held output stalls the input only
// once the pipeline is full. Hue is signed degrees with HUE_FRAC_BITS fraction
// bits, saturation 256 means full (larger values count as full), and zero
// saturation yields grey at the brightness level. Results truncate toward
// zero and clip at 255.

module hsv_to_rgb_core #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // input transactions
    input  wire                                  i_valid,
    output logic                                 o_stall,
    input  wire signed [hsv2rgb_pkg::HUE_W-1:0]  i_hue,
    input  wire [hsv2rgb_pkg::SAT_W-1:0]         i_saturation,
    input  wire [hsv2rgb_pkg::VAL_W-1:0]         i_brightness,
    // output transactions
    output logic                                 o_valid,
    input  wire                                  i_stall,
    output logic [hsv2rgb_pkg::CH_W-1:0]         o_red,
    output logic [hsv2rgb_pkg::CH_W-1:0]         o_green,
    output logic [hsv2rgb_pkg::CH_W-1:0]         o_blue
);

    localparam int SPAN  = 60 << HUE_FRAC_BITS;
    localparam int REM_W = $clog2(SPAN + 1);
    localparam int LVL_W = hsv2rgb_pkg::LVL_W;
    localparam int CH_W  = hsv2rgb_pkg::CH_W;

    // hue stage outputs
    logic                 hue_rdy;
    logic                 hue_vld;
    hsv2rgb_pkg::t_side   in_side;
    hsv2rgb_pkg::t_sector hue_sector;
    logic [REM_W-1:0]     hue_rem;
    hsv2rgb_pkg::t_side   hue_side;

    // level stage outputs
    logic                 lvl_rdy;
    logic                 lvl_vld;
    hsv2rgb_pkg::t_lvl    lvl;

    // output register
    logic             r_o_valid;
    logic [CH_W-1:0]  r_red;
    logic [CH_W-1:0]  r_green;
    logic [CH_W-1:0]  r_blue;
    logic             out_rdy;

    logic [LVL_W-1:0] lvl_q;
    logic [LVL_W-1:0] lvl_t;
    logic [LVL_W-1:0] n_red;
    logic [LVL_W-1:0] n_green;
    logic [LVL_W-1:0] n_blue;

    assign in_side.sat = i_saturation;
    assign in_side.val = i_brightness;
    assign o_stall     = !hue_rdy;

    hsv2rgb_hue #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_hue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (i_valid),
        .o_rdy    (hue_rdy),
        .i_hue    (i_hue),
        .i_side   (in_side),
        .o_vld    (hue_vld),
        .i_rdy    (lvl_rdy),
        .o_sector (hue_sector),
        .o_rem    (hue_rem),
        .o_side   (hue_side)
    );

    hsv2rgb_level #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_level (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (hue_vld),
        .o_rdy    (lvl_rdy),
        .i_sector (hue_sector),
        .i_rem    (hue_rem),
        .i_side   (hue_side),
        .o_vld    (lvl_vld),
        .i_rdy    (out_rdy),
        .o_lvl    (lvl)
    );

    // output register frees up when empty or taken this cycle
    assign out_rdy = !r_o_valid || !i_stall;

    // finish the divide by 60 of q and t
    assign lvl_q = LVL_W'(lvl.q_prod >> hsv2rgb_pkg::DIV60_SHIFT);
    assign lvl_t = LVL_W'(lvl.t_prod >> hsv2rgb_pkg::DIV60_SHIFT);

    // standard sector table, grey overrides it
    always_comb begin
        if (lvl.grey) begin
            n_red   = lvl.val;
            n_green = lvl.val;
            n_blue  = lvl.val;
        end else begin
            unique case (lvl.sector)
                hsv2rgb_pkg::SEC_RY: begin
                    n_red   = lvl.val;
                    n_green = lvl_t;
                    n_blue  = lvl.p;
                end
                hsv2rgb_pkg::SEC_YG: begin
                    n_red   = lvl_q;
                    n_green = lvl.val;
                    n_blue  = lvl.p;
                end
                hsv2rgb_pkg::SEC_GC: begin
                    n_red   = lvl.p;
                    n_green = lvl.val;
                    n_blue  = lvl_t;
                end
                hsv2rgb_pkg::SEC_CB: begin
                    n_red   = lvl.p;
                    n_green = lvl_q;
                    n_blue  = lvl.val;
                end
                hsv2rgb_pkg::SEC_BM: begin
                    n_red   = lvl_t;
                    n_green = lvl.p;
                    n_blue  = lvl.val;
                end
                default: begin
                    n_red   = lvl.val;
                    n_green = lvl.p;
                    n_blue  = lvl_q;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_rdy) begin
            r_o_valid <= lvl_vld;
        end
    end

    // clip each channel at 255
    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_red   <= (n_red   > hsv2rgb_pkg::CH_MAX) ? '1 : n_red[CH_W-1:0];
            r_green <= (n_green > hsv2rgb_pkg::CH_MAX) ? '1 : n_green[CH_W-1:0];
            r_blue  <= (n_blue  > hsv2rgb_pkg::CH_MAX) ? '1 : n_blue[CH_W-1:0];
        end
    end

    assign o_valid = r_o_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

`default_nettype wire
